@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define DTA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true out of reset
`define DTA_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define DTA_ASSERT(label, clk, rst_n, prop)
`define DTA_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/dta_pkg.sv @@
// Shared types and constants of the detection/track associator.
// No dependencies.
package dta_pkg;

    localparam int COORD_W    = 12;
    localparam int CLASS_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int MISS_W     = 8;
    localparam int GAIN_FRAC  = 15;
    localparam int TOL_W      = COORD_W + GAIN_W - GAIN_FRAC;
    localparam int KIND_W     = 2;
    localparam int OUT_ID_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_TAG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CARRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MISSED = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } t_box;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        t_box               box;
        logic [MISS_W-1:0]  missed;
    } t_slot;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OUT_ID_W-1:0] id;
        logic [CLASS_W-1:0]  cls;
        t_box                box;
        logic                full;
        logic                last;
    } t_result;

endpackage

@@ rtl/dta_tol.sv @@
// Tolerance and center unit: floor(span * gain / 2^15) and floor((lo + hi) / 2).
// Depends on dta_pkg.
module dta_tol import dta_pkg::*; (
    input  logic [COORD_W-1:0] i_lo,
    input  logic [COORD_W-1:0] i_hi,
    input  logic [GAIN_W-1:0]  i_gain,
    output logic [TOL_W-1:0]   o_tol,
    output logic [COORD_W-1:0] o_center
);

    logic [COORD_W-1:0]        span;
    logic [COORD_W+GAIN_W-1:0] prod;
    logic [COORD_W:0]          sum;

    // inverted edges give a zero span
    assign span     = (i_hi >= i_lo) ? i_hi - i_lo : '0;
    assign prod     = (COORD_W+GAIN_W)'(span) * (COORD_W+GAIN_W)'(i_gain);
    assign o_tol    = prod[COORD_W+GAIN_W-1:GAIN_FRAC];
    assign sum      = (COORD_W+1)'(i_lo) + (COORD_W+1)'(i_hi);
    assign o_center = sum[COORD_W:1];

endmodule

@@ rtl/dta_mem.sv @@
// Track slot memory: one write port, one read port with registered data.
// No dependencies.
module dta_mem #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/detection_track_associator.sv @@
// Detection: S_DTOL, then per slot S_DNEXT, plus S_DWAIT unless skipped, plus S_DCMP on a
// class match; a new track or full table then takes S_DNEW and S_OUT, a match only S_OUT.
// End of frame: S_ERD and S_ECHK per stored track, S_OUT per carried one, then S_EFIN, S_OUT.
// Output stalls hold the sequencer in its output state until the output register frees up.
// One transaction in flight; the slot scan through the single memory read port sets the pace.
// Reset (synchronous, active low) empties the table, sets the next id to 1, restores registers.
`include "assert_macros.svh"
module detection_track_associator import dta_pkg::*; #(
    parameter int TRACK_SLOTS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [CLASS_W-1:0]    i_class_index,
    input  logic [COORD_W-1:0]    i_left_x,
    input  logic [COORD_W-1:0]    i_top_y,
    input  logic [COORD_W-1:0]    i_right_x,
    input  logic [COORD_W-1:0]    i_bottom_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [OUT_ID_W-1:0]   o_track_id,
    output logic [CLASS_W-1:0]    o_out_class,
    output logic [COORD_W-1:0]    o_out_left,
    output logic [COORD_W-1:0]    o_out_top,
    output logic [COORD_W-1:0]    o_out_right,
    output logic [COORD_W-1:0]    o_out_bottom,
    output logic                  o_table_full,
    output logic                  o_last
);

    localparam int SW    = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int CW    = $clog2(TRACK_SLOTS + 1);
    localparam int SLOT_W = $bits(t_slot);
    localparam int ENT_W = ID_BITS + SLOT_W;
    localparam logic [CW-1:0]      FULL_CNT = CW'(TRACK_SLOTS);
    localparam logic [ID_BITS-1:0] ID_ONE   = ID_BITS'(1);
    localparam logic [ID_BITS-1:0] ID_MAX   = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_DTOL, S_DNEXT, S_DWAIT, S_DCMP, S_DNEW,
        S_ERD, S_ECHK, S_EFIN, S_OUT
    } t_state;

    t_state                  r_state, r_ret;
    logic [GAIN_W-1:0]       r_gain_x, r_gain_y;
    logic [MISS_W-1:0]       r_max_missed;
    logic [CW-1:0]           r_count, r_idx, r_wr;
    logic [ID_BITS-1:0]      r_next_id, r_ent_id;
    logic [TRACK_SLOTS-1:0]  r_matched, r_new;
    logic [SW-1:0]           r_slot;
    logic [CLASS_W-1:0]      r_cls;
    t_box                    r_box;
    logic [TOL_W-1:0]        r_tx, r_ty, r_stx, r_sty;
    logic [COORD_W-1:0]      r_cx, r_cy, r_scx, r_scy;
    t_result                 r_res, r_out;
    logic                    r_ovalid;

    logic                    mem_we;
    logic [SW-1:0]           mem_waddr, mem_raddr;
    logic [ENT_W-1:0]        mem_wdata, mem_rdata;
    logic [ID_BITS-1:0]      rd_id;
    t_slot                   rd_slot;
    t_box                    tol_box;
    logic [TOL_W-1:0]        tol_x, tol_y, min_x, min_y;
    logic [COORD_W-1:0]      ctr_x, ctr_y, dx, dy;
    logic [CW-1:0]           idx_dec, idx_inc;
    logic [SW-1:0]           slot_dn, slot_up;
    logic                    hit, pend, drop;
    logic [MISS_W-1:0]       miss_inc;

    function automatic logic [OUT_ID_W-1:0] id_out(input logic [ID_BITS-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return e[OUT_ID_W-1:0];
    endfunction

    dta_mem #(.WIDTH(ENT_W), .DEPTH(TRACK_SLOTS), .AW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // one tolerance unit per axis, shared between the detection box and slot boxes
    dta_tol u_tol_x (
        .i_lo(tol_box.left), .i_hi(tol_box.right), .i_gain(r_gain_x),
        .o_tol(tol_x), .o_center(ctr_x)
    );
    dta_tol u_tol_y (
        .i_lo(tol_box.top), .i_hi(tol_box.bottom), .i_gain(r_gain_y),
        .o_tol(tol_y), .o_center(ctr_y)
    );

    always_comb begin
        rd_id    = mem_rdata[ENT_W-1 -: ID_BITS];
        rd_slot  = t_slot'(mem_rdata[SLOT_W-1:0]);
        tol_box  = (r_state == S_DTOL) ? r_box : rd_slot.box;
        idx_dec  = r_idx - 1'b1;
        idx_inc  = r_idx + 1'b1;
        slot_dn  = idx_dec[SW-1:0];
        slot_up  = r_idx[SW-1:0];
        dx       = (r_cx >= r_scx) ? r_cx - r_scx : r_scx - r_cx;
        dy       = (r_cy >= r_scy) ? r_cy - r_scy : r_scy - r_cy;
        min_x    = (r_tx < r_stx) ? r_tx : r_stx;
        min_y    = (r_ty < r_sty) ? r_ty : r_sty;
        hit      = (TOL_W'(dx) <= min_x) && (TOL_W'(dy) <= min_y);
        pend     = !r_matched[slot_up] && !r_new[slot_up];
        drop     = pend && (rd_slot.missed > r_max_missed);
        miss_inc = (rd_slot.missed == '1) ? rd_slot.missed : rd_slot.missed + 1'b1;

        mem_raddr = (r_state == S_DNEXT) ? slot_dn : slot_up;
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {r_ent_id, r_cls, r_box, MISS_W'(0)};
        case (r_state)
            S_DCMP: begin
                mem_we = hit;
            end
            S_DNEW: begin
                mem_we    = (r_count < FULL_CNT);
                mem_waddr = r_count[SW-1:0];
                mem_wdata = {r_next_id, r_cls, r_box, MISS_W'(0)};
            end
            S_ECHK: begin
                // compaction: surviving tracks move down to the write pointer
                mem_we    = !drop;
                mem_waddr = r_wr[SW-1:0];
                mem_wdata = {rd_id, rd_slot.cls, rd_slot.box,
                             pend ? miss_inc : rd_slot.missed};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_gain_x     <= GAIN_W'(26214);
            r_gain_y     <= GAIN_W'(26214);
            r_max_missed <= MISS_W'(10);
            r_count      <= '0;
            r_next_id    <= ID_ONE;
            r_matched    <= '0;
            r_new        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_X:     r_gain_x     <= i_cfg_data;
                    REG_GAIN_Y:     r_gain_y     <= i_cfg_data;
                    REG_MAX_MISSED: r_max_missed <= i_cfg_data[MISS_W-1:0];
                    default:        ;
                endcase
            end

            if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cls <= i_class_index;
                        r_box <= '{bottom: i_bottom_y, right: i_right_x,
                                   top: i_top_y, left: i_left_x};
                        r_idx <= '0;
                        r_wr  <= '0;
                        if (!i_mode) begin
                            r_state <= S_DTOL;
                        end else if (r_count == '0) begin
                            r_state <= S_EFIN;
                        end else begin
                            r_state <= S_ERD;
                        end
                    end
                end
                S_DTOL: begin
                    r_tx    <= tol_x;
                    r_ty    <= tol_y;
                    r_cx    <= ctr_x;
                    r_cy    <= ctr_y;
                    r_idx   <= r_count;
                    r_state <= S_DNEXT;
                end
                S_DNEXT: begin
                    // newest first; tracks matched or born this frame are skipped
                    if (r_idx == '0) begin
                        r_state <= S_DNEW;
                    end else begin
                        r_idx  <= idx_dec;
                        r_slot <= slot_dn;
                        if (!r_matched[slot_dn] && !r_new[slot_dn]) begin
                            r_state <= S_DWAIT;
                        end
                    end
                end
                S_DWAIT: begin
                    if (rd_slot.cls != r_cls) begin
                        r_state <= S_DNEXT;
                    end else begin
                        r_ent_id <= rd_id;
                        r_stx    <= tol_x;
                        r_sty    <= tol_y;
                        r_scx    <= ctr_x;
                        r_scy    <= ctr_y;
                        r_state  <= S_DCMP;
                    end
                end
                S_DCMP: begin
                    if (hit) begin
                        r_matched[r_slot] <= 1'b1;
                        r_res   <= '{kind: KIND_TAG, id: id_out(r_ent_id), cls: r_cls,
                                     box: r_box, full: 1'b0, last: 1'b1};
                        r_ret   <= S_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DNEXT;
                    end
                end
                S_DNEW: begin
                    if (r_count >= FULL_CNT) begin
                        r_res <= '{kind: KIND_TAG, id: '0, cls: r_cls,
                                   box: r_box, full: 1'b1, last: 1'b1};
                    end else begin
                        r_new[r_count[SW-1:0]] <= 1'b1;
                        r_count   <= r_count + 1'b1;
                        r_next_id <= (r_next_id == ID_MAX) ? ID_ONE : r_next_id + 1'b1;
                        r_res <= '{kind: KIND_TAG, id: id_out(r_next_id), cls: r_cls,
                                   box: r_box, full: 1'b0, last: 1'b1};
                    end
                    r_ret   <= S_IDLE;
                    r_state <= S_OUT;
                end
                S_ERD: begin
                    r_state <= S_ECHK;
                end
                S_ECHK: begin
                    r_idx <= idx_inc;
                    if (!drop) begin
                        r_wr <= r_wr + 1'b1;
                    end
                    if (pend && !drop) begin
                        r_res <= '{kind: KIND_CARRY, id: id_out(rd_id), cls: rd_slot.cls,
                                   box: rd_slot.box, full: 1'b0, last: 1'b0};
                        r_ret   <= (idx_inc >= r_count) ? S_EFIN : S_ERD;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= (idx_inc >= r_count) ? S_EFIN : S_ERD;
                    end
                end
                S_EFIN: begin
                    r_count   <= r_wr;
                    r_matched <= '0;
                    r_new     <= '0;
                    r_res     <= '{kind: KIND_DONE, id: '0, cls: '0, box: '0,
                                   full: 1'b0, last: 1'b1};
                    r_ret     <= S_IDLE;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out   <= r_res;
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_kind       = r_out.kind;
    assign o_track_id   = r_out.id;
    assign o_out_class  = r_out.cls;
    assign o_out_left   = r_out.box.left;
    assign o_out_top    = r_out.box.top;
    assign o_out_right  = r_out.box.right;
    assign o_out_bottom = r_out.box.bottom;
    assign o_table_full = r_out.full;
    assign o_last       = r_out.last;

    `DTA_NEVER(a_count_range, i_clk, i_rst_n, r_count > FULL_CNT)
    `DTA_NEVER(a_id_nonzero, i_clk, i_rst_n, r_next_id == '0)
    `DTA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)

endmodule
